@@ hw/rtl/kpse_pkg.sv @@
// ----------------------------------------------------------------------------
// kpse_pkg
// Shared types, constants and tables of the keypad scan and PIN entry unit.
// ----------------------------------------------------------------------------
package kpse_pkg;

  localparam int PIN_LENGTH = 6;
  localparam int CURSOR_W   = 3;
  localparam int DIG_IDX_W  = (PIN_LENGTH > 1) ? $clog2(PIN_LENGTH) : 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [3:0] NO_DIGIT = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_DELETE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_D = 3'd5;

  localparam logic RESULT_STATUS = 1'b0;
  localparam logic RESULT_DIGIT  = 1'b1;

  typedef struct packed {
    logic [15:0] first_sample;
    logic [15:0] settled_sample;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic                key_found;
    logic [3:0]          key_code;
    logic [CURSOR_W-1:0] entry_count;
    logic [3:0]          digit;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic edit;
    logic emit_digit;
  } kpse_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic submit;
    logic digit_last;
    logic out_free;
  } kpse_sts_t;

  function automatic logic [3:0] key_to_digit(input logic [3:0] key);
    logic [3:0] d;
    case (key)
      4'd0:    d = 4'd1;
      4'd1:    d = 4'd2;
      4'd2:    d = 4'd3;
      4'd4:    d = 4'd4;
      4'd5:    d = 4'd5;
      4'd6:    d = 4'd6;
      4'd8:    d = 4'd7;
      4'd9:    d = 4'd8;
      4'd10:   d = 4'd9;
      4'd13:   d = 4'd0;
      default: d = NO_DIGIT;
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/kpse_ctrl.sv @@
// ----------------------------------------------------------------------------
// kpse_ctrl
// Sequencer: accept a scan, step the rows, run the editor, emit digits.
// ----------------------------------------------------------------------------
module kpse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kpse_pkg::kpse_sts_t sts,
  output kpse_pkg::kpse_cmd_t cmd
);
  import kpse_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_EDIT  = 2'd2;
  localparam logic [1:0] S_DIGIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_EDIT;
        end
      end
      S_EDIT: begin
        if (sts.out_free) begin
          cmd.edit   = 1'b1;
          state_next = sts.submit ? S_DIGIT : S_IDLE;
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.digit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/kpse_dpath.sv @@
// ----------------------------------------------------------------------------
// kpse_dpath
// Row scanner, PIN editor with key store, configuration and output register.
// ----------------------------------------------------------------------------
module kpse_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  kpse_pkg::kpse_cmd_t              cmd,
  output kpse_pkg::kpse_sts_t              sts,
  input  kpse_pkg::in_item_t               in_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kpse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [3:0]                       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output kpse_pkg::out_item_t              out_data
);
  import kpse_pkg::*;

  logic [3:0] delete_key;
  logic [3:0] enter_key;
  logic [3:0] letter_a_key;
  logic [3:0] letter_b_key;
  logic [3:0] letter_c_key;
  logic [3:0] letter_d_key;

  logic [15:0] first_q;
  logic [15:0] settled_q;
  logic [3:0]  row_released;
  logic [1:0]  row;
  logic        found;
  logic [3:0]  code;

  logic [CURSOR_W-1:0]  cursor;
  logic [CURSOR_W-1:0]  cursor_next;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [3:0]           entered_keys [PIN_LENGTH];

  logic [3:0] snap;
  logic [3:0] calm;
  logic       hit;
  logic [1:0] col;
  logic       wr_en;
  logic       submit_now;
  logic       is_letter;
  logic [3:0] stored_key;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      delete_key   <= 4'd12;
      enter_key    <= 4'd14;
      letter_a_key <= 4'd3;
      letter_b_key <= 4'd7;
      letter_c_key <= 4'd11;
      letter_d_key <= 4'd15;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DELETE:   delete_key   <= cfg_data;
        CFG_ENTER:    enter_key    <= cfg_data;
        CFG_LETTER_A: letter_a_key <= cfg_data;
        CFG_LETTER_B: letter_b_key <= cfg_data;
        CFG_LETTER_C: letter_c_key <= cfg_data;
        CFG_LETTER_D: letter_d_key <= cfg_data;
        default: ;
      endcase
    end
  end

  // row scanner
  assign snap = first_q[{row, 2'b00} +: 4];
  assign calm = settled_q[{row, 2'b00} +: 4];
  assign hit  = row_released[row] && (snap != 4'd0);

  always_comb begin
    if (calm[0]) begin
      col = 2'd0;
    end else if (calm[1]) begin
      col = 2'd1;
    end else if (calm[2]) begin
      col = 2'd2;
    end else begin
      col = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      first_q   <= in_data.first_sample;
      settled_q <= in_data.settled_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_released <= 4'hF;
      row          <= 2'd0;
      found        <= 1'b0;
      code         <= 4'd0;
    end else if (cmd.capture) begin
      row   <= 2'd0;
      found <= 1'b0;
      code  <= 4'd0;
    end else if (cmd.scan_step) begin
      if (hit) begin
        row_released[row] <= 1'b0;
        if (calm != 4'd0) begin
          found <= 1'b1;
          code  <= {row, col};
        end
      end else if (snap == 4'd0) begin
        row_released[row] <= 1'b1;
      end
      row <= row + 2'd1;
    end
  end

  // PIN editor
  assign is_letter = (code == letter_a_key) || (code == letter_b_key) ||
                     (code == letter_c_key) || (code == letter_d_key);

  always_comb begin
    cursor_next = cursor;
    wr_en       = 1'b0;
    submit_now  = 1'b0;
    if (found) begin
      if (code == delete_key) begin
        if (cursor != '0) begin
          cursor_next = cursor - CURSOR_W'(1);
        end
      end else if (cursor < CURSOR_W'(PIN_LENGTH)) begin
        if (code == enter_key) begin
          cursor_next = '0;
        end else if (!is_letter) begin
          wr_en       = 1'b1;
          cursor_next = cursor + CURSOR_W'(1);
        end
      end else begin
        submit_now  = (code == enter_key);
        cursor_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edit && wr_en) begin
      entered_keys[cursor[DIG_IDX_W-1:0]] <= code;
    end
  end

  assign stored_key = entered_keys[dig_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      dig_idx <= '0;
    end else if (cmd.edit) begin
      cursor  <= cursor_next;
      dig_idx <= '0;
    end else if (cmd.emit_digit) begin
      dig_idx <= dig_idx + DIG_IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.edit || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edit) begin
      out_data.result_kind <= RESULT_STATUS;
      out_data.key_found   <= found;
      out_data.key_code    <= found ? code : 4'd0;
      out_data.entry_count <= cursor_next;
      out_data.digit       <= NO_DIGIT;
      out_data.last        <= !submit_now;
    end else if (cmd.emit_digit) begin
      out_data.result_kind <= RESULT_DIGIT;
      out_data.key_found   <= 1'b1;
      out_data.key_code    <= stored_key;
      out_data.entry_count <= cursor;
      out_data.digit       <= key_to_digit(stored_key);
      out_data.last        <= (dig_idx == DIG_IDX_W'(PIN_LENGTH - 1));
    end
  end

  assign sts.scan_done  = (hit && (calm != 4'd0)) || (row == 2'd3);
  assign sts.submit     = submit_now;
  assign sts.digit_last = (dig_idx == DIG_IDX_W'(PIN_LENGTH - 1));
  assign sts.out_free   = !out_valid || out_ready;

endmodule

@@ hw/rtl/keypad_scan_pin_entry_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_pin_entry_unit
// 4x4 keypad scanner feeding a PIN entry editor; emits a status result per
// scan and, on submit, one digit result per stored key.
// ----------------------------------------------------------------------------
//  channel | signals                               | role
//  in      | in_valid, in_ready, in_data           | one keypad scan
//  out     | out_valid, out_ready, out_data        | status and digit results
//  cfg     | cfg_valid, cfg_ready, cfg_index/_data | key code registers
//
//  A scan has an accept step, a row scan over 1 to 4 rows (one row per cycle, stop at
//  the first new key) and an editor step that loads the status result.
//  A submit then emits one digit result per stored key, 6 in all, through the output register.
//  The next scan is accepted while the last result still waits in the output
//  register; an output stall holds the editor and digit steps.
//  Reset restores rows released, cursor zero and the default key codes.
// ----------------------------------------------------------------------------
module keypad_scan_pin_entry_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kpse_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kpse_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kpse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]                     cfg_data
);
  import kpse_pkg::*;

  kpse_cmd_t cmd;
  kpse_sts_t sts;

  kpse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kpse_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/kpse_checker.sv @@
// ----------------------------------------------------------------------------
// kpse_checker
// Port-level checks of the keypad scan and PIN entry unit.
// ----------------------------------------------------------------------------
module kpse_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input kpse_pkg::out_item_t out_data
);
  import kpse_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_digit_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == RESULT_DIGIT) |->
      out_data.key_found && (out_data.entry_count == '0))
    else $error("digit result with bad found flag or count");

  a_status_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == RESULT_STATUS) |->
      (out_data.digit == NO_DIGIT))
    else $error("status result carries a digit");

  a_no_key_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == RESULT_STATUS) && !out_data.key_found |->
      (out_data.key_code == 4'd0) && out_data.last)
    else $error("status without key has code or continues");

endmodule

bind keypad_scan_pin_entry_unit kpse_checker u_kpse_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
